// ===== hdl/gdd_pkg.sv =====
package gdd_pkg;

   // Field widths of one beat on each channel.
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DIST_W  = 22;

   // Largest year the 14-bit field can carry.
   localparam int YEAR_FIELD_MAX = 16383;

   // Calendar constants.
   localparam int DAYS_IN_YEAR      = 365;
   localparam int YEARS_PER_CENTURY = 100;
   localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

   // A quotient by 25 is taken as a multiply by this reciprocal and a shift.
   // It is exact for every dividend below 4096, which covers the year field
   // divided by four.
   localparam int RECIP_25    = 5243;
   localparam int RECIP_SHIFT = 17;

   // Quotient of a year by one hundred: at most 163.
   localparam int CENT_W = 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture both dates
      logic quot;   // century quotient and base count of one date
      logic accum;  // century corrections and leap day of one date
      logic sel;    // which date the two steps above work on
      logic diff;   // absolute difference into the result register
   } gdd_cmd_type;

   // Days in the months before a given month of a common year. Month zero
   // has no months before it, and any month above twelve counts the whole
   // year.
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] mon);
      logic [8:0] days;
      case (mon)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd365;
      endcase
      return days;
   endfunction

endpackage

// ===== hdl/gdd_ctrl.sv =====
module gdd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gdd_pkg::gdd_cmd_type cmd
);
   import gdd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT_A,
      ST_ACCUM_A,
      ST_QUOT_B,
      ST_ACCUM_B,
      ST_DIFF
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // The result register can take a new value once it is empty or being read.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer and result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The flag rises as a new difference lands and falls once the beat is read.
         if ((state_ff == ST_DIFF) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_QUOT_A;
               end
            end
            ST_QUOT_A:  state_ff <= ST_ACCUM_A;
            ST_ACCUM_A: state_ff <= ST_QUOT_B;
            ST_QUOT_B:  state_ff <= ST_ACCUM_B;
            ST_ACCUM_B: state_ff <= ST_DIFF;
            ST_DIFF: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.quot  = (state_ff == ST_QUOT_A) || (state_ff == ST_QUOT_B);
      cmd.accum = (state_ff == ST_ACCUM_A) || (state_ff == ST_ACCUM_B);
      cmd.sel   = (state_ff == ST_QUOT_B) || (state_ff == ST_ACCUM_B);
      cmd.diff  = (state_ff == ST_DIFF) && out_free;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/gdd_datapath.sv =====
module gdd_datapath #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                        clock,
   input  gdd_pkg::gdd_cmd_type        cmd,
   input  logic [gdd_pkg::DAY_W-1:0]   req_first_day,
   input  logic [gdd_pkg::MONTH_W-1:0] req_first_month,
   input  logic [gdd_pkg::YEAR_W-1:0]  req_first_year,
   input  logic [gdd_pkg::DAY_W-1:0]   req_second_day,
   input  logic [gdd_pkg::MONTH_W-1:0] req_second_month,
   input  logic [gdd_pkg::YEAR_W-1:0]  req_second_year,
   output logic [gdd_pkg::DIST_W-1:0]  rsp_day_distance
);
   import gdd_pkg::*;

   // Years saturate here; the count width follows from it.
   localparam int YEAR_CAP = (MAX_YEAR > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : MAX_YEAR;
   localparam int CNT_W    = $clog2(366 * (YEAR_CAP + 2) + 1);
   localparam int EXT_W    = (CNT_W > DIST_W) ? CNT_W : DIST_W;

   logic [DAY_W-1:0]   day_ff   [2];
   logic [MONTH_W-1:0] month_ff [2];
   logic [YEAR_W-1:0]  year_ff  [2];
   logic [YEAR_W-1:0]  year_a_in;
   logic [YEAR_W-1:0]  year_b_in;

   logic [CENT_W-1:0]  cent_ff;
   logic [CENT_W-1:0]  cent_in;
   logic [CNT_W-1:0]   base_ff;
   logic [CNT_W-1:0]   base_in;
   logic [CNT_W-1:0]   count_ff [2];
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   dist_ff;
   logic [CNT_W-1:0]   dist_in;
   logic [EXT_W-1:0]   dist_ext;

   logic [YEAR_W-1:0]  yr;
   logic [MONTH_W-1:0] mon;
   logic [DAY_W-1:0]   dy;
   logic [24:0]        cent_prod;
   logic [YEAR_W:0]    quad_sum;
   logic [YEAR_W-1:0]  cent_rem;
   logic               rem_nz;
   logic               cent_div4;
   logic               leap;
   logic               leap_adj;
   logic [CENT_W:0]    ceil_cent;
   logic [CENT_W-2:0]  ceil_quad_cent;

   // Saturate the years on capture.
   always_comb begin
      year_a_in = (17'(req_first_year) > 17'(YEAR_CAP)) ? YEAR_W'(YEAR_CAP) : req_first_year;
      year_b_in = (17'(req_second_year) > 17'(YEAR_CAP)) ? YEAR_W'(YEAR_CAP) : req_second_year;
   end

   always_comb begin
      yr  = year_ff[cmd.sel];
      mon = month_ff[cmd.sel];
      dy  = day_ff[cmd.sel];
   end

   // Step one: year by one hundred through the reciprocal, and the count of
   // whole common years, fourth years, prior months and the day.
   always_comb begin
      cent_prod = 25'(yr[YEAR_W-1:2]) * 25'(RECIP_25);
      cent_in   = cent_prod[RECIP_SHIFT +: CENT_W];
      quad_sum  = (YEAR_W+1)'(yr) + (YEAR_W+1)'(3);
      base_in   = CNT_W'(yr) * CNT_W'(DAYS_IN_YEAR)
                + CNT_W'(quad_sum[YEAR_W:2])
                + CNT_W'(month_start(mon))
                + CNT_W'(dy);
   end

   // Step two: remainder by one hundred gives the century corrections and
   // the leap test; February's extra day counts from March on.
   always_comb begin
      cent_rem       = yr - YEAR_W'(15'(cent_ff) * 15'(YEARS_PER_CENTURY));
      rem_nz         = (cent_rem != '0);
      cent_div4      = (cent_ff[1:0] == 2'd0);
      leap           = ((yr[1:0] == 2'd0) && rem_nz) || (!rem_nz && cent_div4);
      leap_adj       = leap && (mon >= MONTH_MARCH);
      ceil_cent      = (CENT_W+1)'(cent_ff) + (CENT_W+1)'(rem_nz);
      ceil_quad_cent = (CENT_W-1)'(cent_ff[CENT_W-1:2])
                     + (CENT_W-1)'(!(!rem_nz && cent_div4));
      count_in       = base_ff + CNT_W'(ceil_quad_cent) + CNT_W'(leap_adj)
                     - CNT_W'(ceil_cent);
   end

   // Absolute difference of the two counts.
   always_comb begin
      dist_in = (count_ff[0] > count_ff[1]) ? (count_ff[0] - count_ff[1])
                                            : (count_ff[1] - count_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff[0]   <= req_first_day;
         month_ff[0] <= req_first_month;
         year_ff[0]  <= year_a_in;
         day_ff[1]   <= req_second_day;
         month_ff[1] <= req_second_month;
         year_ff[1]  <= year_b_in;
      end
      if (cmd.quot) begin
         cent_ff <= cent_in;
         base_ff <= base_in;
      end
      if (cmd.accum) begin
         count_ff[cmd.sel] <= count_in;
      end
      if (cmd.diff) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_ext         = EXT_W'(dist_ff);
   assign rsp_day_distance = dist_ext[DIST_W-1:0];

endmodule

// ===== hdl/gregorian_day_difference_top.sv =====
// Days between two Gregorian dates. A beat carries two dates (day, month,
// year) and returns one beat with the absolute number of days between them.
// Each date becomes a day count from year zero: whole years, months before
// its month with February at 29 in leap years, and the day as given. Years
// above MAX_YEAR saturate to it, and months above twelve count the whole
// year. A sequencer takes each date through one shared datapath in two
// steps (a reciprocal multiply for the century quotient, then the
// corrections) and then forms the difference, which waits for a free
// output register. The input is stalled until an item is through the
// sequence. The result waits in an output register, and the next item is
// taken while it waits.
module gregorian_day_difference_top #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [gdd_pkg::DAY_W-1:0]   req_first_day,
   input  logic [gdd_pkg::MONTH_W-1:0] req_first_month,
   input  logic [gdd_pkg::YEAR_W-1:0]  req_first_year,
   input  logic [gdd_pkg::DAY_W-1:0]   req_second_day,
   input  logic [gdd_pkg::MONTH_W-1:0] req_second_month,
   input  logic [gdd_pkg::YEAR_W-1:0]  req_second_year,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gdd_pkg::DIST_W-1:0]  rsp_day_distance
);
   import gdd_pkg::*;

   gdd_cmd_type cmd;

   gdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gdd_datapath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_first_day    (req_first_day),
      .req_first_month  (req_first_month),
      .req_first_year   (req_first_year),
      .req_second_day   (req_second_day),
      .req_second_month (req_second_month),
      .req_second_year  (req_second_year),
      .rsp_day_distance (rsp_day_distance)
   );

`ifndef SYNTHESIS
   // A beat taken starts the sequence, so the input is busy next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not busy after an accepted beat");

   // A new result only appears at the end of a busy sequence.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a sequence");

   // No result leaves while the output is stalled and a new one is pending.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("pending result dropped under stall");
`endif

endmodule
